### rtl/bdlp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdlp_pkg: shared types and codes for the button debounce block
// item, result and configuration records plus register and event codes
// ----------------------------------------------------------------------------
package bdlp_pkg;

  localparam int unsigned NOW_W  = 32;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned EV_W   = 2;

  // configuration register indexes
  localparam logic REG_DEBOUNCE_TIME   = 1'b0;
  localparam logic REG_LONG_PRESS_TIME = 1'b1;

  // item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_RESYNC = 1'b1;

  typedef enum logic [EV_W-1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } bdlp_event_t;

  typedef struct packed {
    logic             kind;
    logic             raw_level;
    logic [NOW_W-1:0] now_ms;
  } bdlp_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] long_press_time;
  } bdlp_cfg_t;

  typedef struct packed {
    logic [EV_W-1:0] event_res;
    logic            is_down;
  } bdlp_result_t;

endpackage

`default_nettype wire

### rtl/bdlp_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdlp_core: debounce and press classification step
// holds the debounce state and computes one result per step strobe
// ----------------------------------------------------------------------------
module bdlp_core
  import bdlp_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step,
  input  wire bdlp_item_t   item,
  input  wire bdlp_cfg_t    cfg,
  output bdlp_result_t      result
);

  logic                 last_raw_r, last_raw_nxt;
  logic [TIME_BITS-1:0] change_stamp_r, change_stamp_nxt;
  logic                 stable_level_r, stable_level_nxt;
  logic [TIME_BITS-1:0] press_stamp_r, press_stamp_nxt;
  logic                 long_done_r, long_done_nxt;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] el_change;
  logic [TIME_BITS-1:0] el_press;
  logic [TIME_BITS-1:0] deb_t;
  logic [TIME_BITS-1:0] lpt_t;
  logic                 settle;
  logic                 press_now;
  logic                 long_hit;
  bdlp_event_t          ev;

  assign now_t     = TIME_BITS'(item.now_ms);
  assign deb_t     = TIME_BITS'(cfg.debounce_time);
  assign lpt_t     = TIME_BITS'(cfg.long_press_time);
  assign el_change = now_t - change_stamp_r;
  assign el_press  = now_t - press_stamp_r;

  // raw level steady and different from debounced level for long enough
  assign settle    = (item.raw_level == last_raw_r) && (item.raw_level != stable_level_r) &&
                     (el_change >= deb_t);
  assign press_now = settle && item.raw_level;
  // a press in this step restarts the hold timer at zero elapsed
  assign long_hit  = press_now ? (lpt_t == '0) : (el_press >= lpt_t);

  always_comb begin
    last_raw_nxt     = last_raw_r;
    change_stamp_nxt = change_stamp_r;
    stable_level_nxt = stable_level_r;
    press_stamp_nxt  = press_stamp_r;
    long_done_nxt    = long_done_r;
    ev               = EV_NONE;
    if (item.kind == KIND_RESYNC) begin
      last_raw_nxt     = item.raw_level;
      stable_level_nxt = item.raw_level;
      change_stamp_nxt = now_t;
      press_stamp_nxt  = now_t;
      long_done_nxt    = item.raw_level;
    end else begin
      if (item.raw_level != last_raw_r) begin
        last_raw_nxt     = item.raw_level;
        change_stamp_nxt = now_t;
      end else if (settle) begin
        stable_level_nxt = item.raw_level;
        if (item.raw_level) begin
          press_stamp_nxt = now_t;
          long_done_nxt   = 1'b0;
        end else if (!long_done_r) begin
          ev = EV_SHORT;
        end
      end
      if (stable_level_nxt && !long_done_nxt && long_hit) begin
        long_done_nxt = 1'b1;
        ev            = EV_LONG;
      end
    end
  end

  assign result.event_res = ev;
  assign result.is_down   = stable_level_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r     <= 1'b0;
      change_stamp_r <= '0;
      stable_level_r <= 1'b0;
      press_stamp_r  <= '0;
      long_done_r    <= 1'b0;
    end else if (step) begin
      last_raw_r     <= last_raw_nxt;
      change_stamp_r <= change_stamp_nxt;
      stable_level_r <= stable_level_nxt;
      press_stamp_r  <= press_stamp_nxt;
      long_done_r    <= long_done_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/button_debounce_long_press.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_debounce_long_press: debounced button with short and long press events
//
// in_*  : one transfer per button sample (sample or resync) with its ms stamp
// out_* : one transfer per input item, event code and debounced level
// cfg_* : write-only register port, debounce time (index 0) and long press
//         time (index 1), both in ms; write only while the block is idle
//
// out_valid rises, and the earliest result transfer can happen, once the input
// transfer has passed an input register, then the step logic feeding the
// result register
// throughput is one item per cycle while out_ready is high, set by the single state update per step
// when the receiver stalls, the result register holds and the input register
// fills; in_ready drops only when both are occupied
// reset clears all debounce state and both pipeline valids, and loads the
// registers with 20 ms and 1000 ms
// ----------------------------------------------------------------------------
module button_debounce_long_press
  import bdlp_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // input channel
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_kind,
  input  wire logic             in_raw_level,
  input  wire logic [NOW_W-1:0] in_now_ms,
  // result channel
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [EV_W-1:0]       out_event_res,
  output logic                  out_is_down,
  // configuration
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  // configuration registers
  bdlp_cfg_t    cfg_r;

  // input register
  logic         in_vld_r;
  bdlp_item_t   item_r;

  // result register
  logic         out_vld_r;
  bdlp_result_t res_r;
  bdlp_result_t res_nxt;

  logic         advance;

  // result register frees up when empty or being taken
  assign advance  = !out_vld_r || out_ready;
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time   <= CFG_W'(20);
      cfg_r.long_press_time <= CFG_W'(1000);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE_TIME:   cfg_r.debounce_time   <= cfg_wdata;
        REG_LONG_PRESS_TIME: cfg_r.long_press_time <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.kind      <= in_kind;
      item_r.raw_level <= in_raw_level;
      item_r.now_ms    <= in_now_ms;
    end
  end

  // step logic, state advances when the item moves into the result register
  bdlp_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (in_vld_r && advance),
    .item   (item_r),
    .cfg    (cfg_r),
    .result (res_nxt)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_event_res = res_r.event_res;
  assign out_is_down   = res_r.is_down;

  // a short press is reported on release, so the button is up
  a_short_up: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res == EV_SHORT) |-> !out_is_down)
    else $error("short event with button down");

  // a long press is reported while held
  a_long_down: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res == EV_LONG) |-> out_is_down)
    else $error("long event with button up");

  // only defined event codes leave the block
  a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_event_res == EV_NONE || out_event_res == EV_SHORT ||
                   out_event_res == EV_LONG))
    else $error("undefined event code");

  // an empty result register never blocks the input
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

`default_nettype wire
